/* hdl/krc_pkg.sv */
// krc_pkg: types and constants shared by the keying run coalescer.
// No dependencies; compile first.
package krc_pkg;

	localparam int MAX_CAPACITY = 512;
	localparam int CAP_MIN      = 16;
	localparam int COUNTER_BITS = 32;

	localparam int CFG_W   = 10;
	localparam int DUR_W   = 32;
	localparam int CONFI_W = 12;
	localparam int CONF_W  = 11;
	localparam int TS_W    = 64;
	localparam int ID_W    = 64;
	localparam int CNTO_W  = 32;
	localparam int OCC_W   = $clog2(MAX_CAPACITY + 1);
	localparam int NUM_W   = DUR_W + CONF_W;
	localparam int QCNT_W  = $clog2(CONF_W);

	localparam logic [CONF_W-1:0] CONF_ONE    = CONF_W'(1024);
	localparam logic [CFG_W-1:0]  CFG_RST_VAL = CFG_W'(256);

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	localparam logic [1:0] STATUS_NEW    = 2'd0;
	localparam logic [1:0] STATUS_MERGE  = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;
	localparam logic [1:0] STATUS_CLEAR  = 2'd3;

	typedef struct packed {
		logic               func;
		logic               keyed;
		logic [DUR_W-1:0]   duration_us;
		logic [CONFI_W-1:0] confidence_in;
		logic [TS_W-1:0]    start_time;
		logic [TS_W-1:0]    end_time;
	} krc_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   run_id;
		logic              run_keyed;
		logic [DUR_W-1:0]  run_duration;
		logic [CONF_W-1:0] run_confidence;
		logic [TS_W-1:0]   run_start;
		logic [TS_W-1:0]   run_end;
		logic              evicted;
		logic              truncated;
		logic [CNTO_W-1:0] rejected_count;
		logic [CNTO_W-1:0] coalesced_count;
	} krc_result_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic sum;
		logic div_start;
		logic commit;
	} krc_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       div_done;
	} krc_sts_t;

endpackage

/* hdl/krc_if.sv */
// krc_if: valid/ready channel interfaces for items and results.
// Depends on krc_pkg.
interface krc_item_if import krc_pkg::*; ();
	logic      valid;
	logic      ready;
	krc_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface krc_result_if import krc_pkg::*; ();
	logic        valid;
	logic        ready;
	krc_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/krc_div.sv */
// krc_div: restoring divider, one quotient bit per cycle.
// Depends on krc_pkg. Quotient must fit CONF_W bits.
module krc_div import krc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DUR_W-1:0]  den,
	output logic [CONF_W-1:0] quot,
	output logic              done
);

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  den_sh_q;
	logic [CONF_W-1:0] quot_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = rem_q >= den_sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= QCNT_W'(CONF_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= num;
			den_sh_q <= NUM_W'(den) << (CONF_W - 1);
			quot_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_sh_q;
			end
			quot_q   <= {quot_q[CONF_W-2:0], ge};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

/* hdl/krc_dp.sv */
// krc_dp: datapath of the coalescer: stored run, counters, checks,
// weighted-confidence arithmetic and result register. Depends on krc_pkg, krc_div.
module krc_dp import krc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_data,
	input  krc_item_t         item_data,
	input  krc_cmd_t          cmd,
	output krc_sts_t          sts,
	output krc_result_t       res
);

	krc_item_t         item_q;
	logic [1:0]        kind_q;
	logic [CONF_W-1:0] conf_q;
	logic              has_ts_q;
	logic [DUR_W:0]    sum_q;
	logic [NUM_W-1:0]  prod_a_q;
	logic [NUM_W-1:0]  prod_b_q;
	logic [NUM_W-1:0]  num_q;
	krc_result_t       res_q;

	logic [CFG_W-1:0]        max_obs_q;
	logic                    last_valid_q;
	logic                    last_keyed_q;
	logic [DUR_W-1:0]        last_dur_q;
	logic [CONF_W-1:0]       last_conf_q;
	logic [TS_W-1:0]         last_start_q;
	logic [TS_W-1:0]         last_end_q;
	logic [ID_W-1:0]         last_id_q;
	logic [ID_W-1:0]         next_id_q;
	logic [OCC_W-1:0]        occ_q;
	logic                    trunc_q;
	logic [COUNTER_BITS-1:0] rej_cnt_q;
	logic [COUNTER_BITS-1:0] mrg_cnt_q;

	logic                    n_last_valid;
	logic                    n_last_keyed;
	logic [DUR_W-1:0]        n_last_dur;
	logic [CONF_W-1:0]       n_last_conf;
	logic [TS_W-1:0]         n_last_start;
	logic [TS_W-1:0]         n_last_end;
	logic [ID_W-1:0]         n_last_id;
	logic [ID_W-1:0]         n_next_id;
	logic [OCC_W-1:0]        n_occ;
	logic                    n_trunc;
	logic [COUNTER_BITS-1:0] n_rej_cnt;
	logic [COUNTER_BITS-1:0] n_mrg_cnt;
	logic                    n_evicted;
	krc_result_t             res_d;

	logic [CONF_W-1:0] conf_sat;
	logic              has_ts;
	logic              prev_ts;
	logic [DUR_W:0]    sum;
	logic [1:0]        kind;
	logic [NUM_W-1:0]  prod_a;
	logic [NUM_W-1:0]  prod_b;
	logic [OCC_W-1:0]  cap;
	logic [CONF_W-1:0] quot;
	logic              div_done;

	krc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (sum_q[DUR_W-1:0]),
		.quot   (quot),
		.done   (div_done)
	);

	always_comb begin
		conf_sat = (item_q.confidence_in > CONFI_W'(CONF_ONE)) ? CONF_ONE
			: item_q.confidence_in[CONF_W-1:0];
		has_ts  = (item_q.start_time != '0) || (item_q.end_time != '0);
		prev_ts = (last_start_q != '0) || (last_end_q != '0);
		sum     = {1'b0, last_dur_q} + {1'b0, item_q.duration_us};
		prod_a  = NUM_W'(last_conf_q) * NUM_W'(last_dur_q);
		prod_b  = NUM_W'(conf_sat) * NUM_W'(item_q.duration_us);
		if (item_q.func == FUNC_CLEAR) begin
			kind = STATUS_CLEAR;
		end else if (item_q.duration_us == '0) begin
			kind = STATUS_REJECT;
		end else if (has_ts && (item_q.end_time <= item_q.start_time)) begin
			kind = STATUS_REJECT;
		end else if (last_valid_q && ((has_ts != prev_ts)
				|| (has_ts && (item_q.start_time < last_end_q)))) begin
			kind = STATUS_REJECT;
		end else if (last_valid_q && (last_keyed_q == item_q.keyed)) begin
			if ((has_ts && (item_q.start_time != last_end_q)) || sum[DUR_W]) begin
				kind = STATUS_REJECT;
			end else begin
				kind = STATUS_MERGE;
			end
		end else if (next_id_q == '1) begin
			kind = STATUS_REJECT;
		end else begin
			kind = STATUS_NEW;
		end
	end

	always_comb begin
		if (32'(max_obs_q) < CAP_MIN) begin
			cap = OCC_W'(CAP_MIN);
		end else if (32'(max_obs_q) > MAX_CAPACITY) begin
			cap = OCC_W'(MAX_CAPACITY);
		end else begin
			cap = OCC_W'(max_obs_q);
		end
	end

	always_comb begin
		n_last_valid = last_valid_q;
		n_last_keyed = last_keyed_q;
		n_last_dur   = last_dur_q;
		n_last_conf  = last_conf_q;
		n_last_start = last_start_q;
		n_last_end   = last_end_q;
		n_last_id    = last_id_q;
		n_next_id    = next_id_q;
		n_occ        = occ_q;
		n_trunc      = trunc_q;
		n_rej_cnt    = rej_cnt_q;
		n_mrg_cnt    = mrg_cnt_q;
		n_evicted    = 1'b0;
		res_d        = '0;
		case (kind_q)
			STATUS_CLEAR: begin
				n_last_valid = 1'b0;
				n_last_keyed = 1'b0;
				n_last_dur   = '0;
				n_last_conf  = '0;
				n_last_start = '0;
				n_last_end   = '0;
				n_last_id    = '0;
				n_occ        = '0;
				n_trunc      = 1'b0;
				n_rej_cnt    = '0;
				n_mrg_cnt    = '0;
			end
			STATUS_REJECT: begin
				if (rej_cnt_q != '1) begin
					n_rej_cnt = rej_cnt_q + 1'b1;
				end
			end
			STATUS_MERGE: begin
				n_last_conf = quot;
				n_last_dur  = sum_q[DUR_W-1:0];
				if (has_ts_q) begin
					n_last_end = item_q.end_time;
				end
				if (mrg_cnt_q != '1) begin
					n_mrg_cnt = mrg_cnt_q + 1'b1;
				end
			end
			STATUS_NEW: begin
				n_last_id    = next_id_q;
				n_next_id    = next_id_q + 1'b1;
				n_last_valid = 1'b1;
				n_last_keyed = item_q.keyed;
				n_last_dur   = item_q.duration_us;
				n_last_conf  = conf_q;
				n_last_start = item_q.start_time;
				n_last_end   = item_q.end_time;
				if (occ_q >= cap) begin
					n_occ     = cap;
					n_evicted = 1'b1;
					n_trunc   = 1'b1;
				end else begin
					n_occ = occ_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.status = kind_q;
		if ((kind_q == STATUS_NEW) || (kind_q == STATUS_MERGE)) begin
			res_d.run_id         = n_last_id;
			res_d.run_keyed      = n_last_keyed;
			res_d.run_duration   = n_last_dur;
			res_d.run_confidence = n_last_conf;
			res_d.run_start      = n_last_start;
			res_d.run_end        = n_last_end;
			res_d.evicted        = n_evicted;
		end
		res_d.truncated       = n_trunc;
		res_d.rejected_count  = CNTO_W'(n_rej_cnt);
		res_d.coalesced_count = CNTO_W'(n_mrg_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_obs_q    <= CFG_RST_VAL;
			last_valid_q <= 1'b0;
			last_keyed_q <= 1'b0;
			last_dur_q   <= '0;
			last_conf_q  <= '0;
			last_start_q <= '0;
			last_end_q   <= '0;
			last_id_q    <= '0;
			next_id_q    <= ID_W'(1);
			occ_q        <= '0;
			trunc_q      <= 1'b0;
			rej_cnt_q    <= '0;
			mrg_cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				max_obs_q <= cfg_data;
			end
			if (cmd.commit) begin
				last_valid_q <= n_last_valid;
				last_keyed_q <= n_last_keyed;
				last_dur_q   <= n_last_dur;
				last_conf_q  <= n_last_conf;
				last_start_q <= n_last_start;
				last_end_q   <= n_last_end;
				last_id_q    <= n_last_id;
				next_id_q    <= n_next_id;
				occ_q        <= n_occ;
				trunc_q      <= n_trunc;
				rej_cnt_q    <= n_rej_cnt;
				mrg_cnt_q    <= n_mrg_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
		end
		if (cmd.check) begin
			kind_q   <= kind;
			conf_q   <= conf_sat;
			has_ts_q <= has_ts;
			sum_q    <= sum;
			prod_a_q <= prod_a;
			prod_b_q <= prod_b;
		end
		if (cmd.sum) begin
			num_q <= prod_a_q + prod_b_q;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	assign sts.kind     = kind_q;
	assign sts.div_done = div_done;
	assign res          = res_q;

endmodule

/* hdl/krc_ctrl.sv */
// krc_ctrl: sequencer of the coalescer; owns both handshakes.
// Depends on krc_pkg.
module krc_ctrl import krc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  krc_sts_t sts,
	output krc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_SUM    = 3'd2;
	localparam logic [2:0] ST_DIVGO  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = (sts.kind == STATUS_MERGE) ? ST_DIVGO : ST_COMMIT;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/keying_run_coalescer.sv */
// Keying run coalescer: takes one observation at a time and returns one result
// transaction per item. A clear, rejected or new run passes from acceptance
// through the check, sum and commit states; a merge also passes through the
// divider start and divide states, where the restoring divider forms the
// duration-weighted confidence. The result sits in an output
// register, so the next transaction is accepted while a result waits; a new result
// is committed only once the previous one has been taken. The capacity register
// may be written only while no transaction is in flight.
// Depends on krc_pkg, krc_if, krc_ctrl, krc_dp.
module keying_run_coalescer import krc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	krc_item_if.sink         item,
	krc_result_if.source     result
);

	krc_cmd_t cmd;
	krc_sts_t sts;

	krc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	krc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.item_data (item.data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (result.data)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!result.valid || result.ready))
		else $error("result overwritten before taken");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result.valid)
		else $error("committed result not presented");

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.run_confidence <= CONF_ONE))
		else $error("run confidence above unity");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.data.status == STATUS_REJECT)) |->
		(result.data.run_id == '0))
		else $error("rejected result carries a run id");

endmodule
